// ===== hw/rtl/event_countdown_scheduler_assert.svh =====
// assertion macros used by the scheduler back end
// every macro samples on clk_i and is disabled while rst_ni is low
`ifndef EVENT_COUNTDOWN_SCHEDULER_ASSERT_SVH
`define EVENT_COUNTDOWN_SCHEDULER_ASSERT_SVH

// property holds at every edge out of reset
`define ECS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("ecs assertion failed");

// condition implies a consequence in the next cycle
`define ECS_ASSERT_NEXT(lbl, cond, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |=> (cons)) \
    else $error("ecs assertion failed");

`endif

// ===== hw/rtl/ecs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ecs_pkg;

  localparam int NUM_EVENTS = 16;
  localparam int TIME_BITS  = 48;
  localparam int SLOT_W     = $clog2(NUM_EVENTS);

  // port field widths
  localparam int ACTION_W = 3;
  localparam int HIDX_W   = 4;
  localparam int CT_W     = 40;
  localparam int EL_W     = 16;
  localparam int COUNT_W  = 48;

  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  localparam logic [ACTION_W-1:0] ACT_ADVANCE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_ADD     = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_REMOVE  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ACK     = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_QUERY   = 3'd4;

  typedef logic signed [TIME_BITS-1:0] time_t;

  localparam time_t TIME_MAX = time_t'({1'b0, {(TIME_BITS-1){1'b1}}});
  localparam time_t TIME_MIN = time_t'({1'b1, {(TIME_BITS-1){1'b0}}});

  typedef enum logic [2:0] {
    OP_ADVANCE,
    OP_ADD,
    OP_REMOVE,
    OP_ACK,
    OP_QUERY,
    OP_NOP
  } op_e;

  typedef struct packed {
    op_e                   op;
    logic                  slot_ok;
    logic [SLOT_W-1:0]     slot;
    time_t                 ct;
    logic [EL_W-1:0]       el;
  } cmd_t;

  typedef struct packed {
    logic [HIDX_W-1:0]         next_index;
    logic signed [COUNT_W-1:0] next_count;
    logic                      any_pending;
    logic                      query_active;
  } res_t;

  // a - b clamped to the signed time range
  function automatic time_t sat_sub(time_t a, time_t b);
    logic signed [TIME_BITS:0] d;
    time_t r;
    d = {a[TIME_BITS-1], a} - {b[TIME_BITS-1], b};
    if (d[TIME_BITS] != d[TIME_BITS-1]) begin
      r = d[TIME_BITS] ? TIME_MIN : TIME_MAX;
    end else begin
      r = time_t'(d);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/event_countdown_scheduler.sv =====
`timescale 1ns / 1ps
`default_nettype none

// channel   | handshake            | words
// ----------+----------------------+---------------------------------------------
// command   | push_i / full_o      | action_i, handler_index_i, cycle_time_i,
//           |                      | elapsed_cycles_i
// result    | empty_o / pop_i      | next_index_o, next_count_o, any_pending_o,
//           |                      | query_active_o
//
// advance, query and unknown actions finish in the cycle the back end takes them
// add, remove and acknowledge run the one-slot-per-cycle rebase and minimum sweep
//   over the slot time ram
// a two-word command queue lets the host push while a sweep runs
// a one-word result register holds the answer until popped; the back end waits
//   only when that register is still full
// reset clears the active flags, soonest slot and countdown at once; no clearing
//   pass, since the time of an inactive slot is never read

module event_countdown_scheduler (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                push_i,
  output logic                                     full_o,
  input  wire logic [ecs_pkg::ACTION_W-1:0]        action_i,
  input  wire logic [ecs_pkg::HIDX_W-1:0]          handler_index_i,
  input  wire logic [ecs_pkg::CT_W-1:0]            cycle_time_i,
  input  wire logic [ecs_pkg::EL_W-1:0]            elapsed_cycles_i,
  output logic                                     empty_o,
  input  wire logic                                pop_i,
  output logic      [ecs_pkg::HIDX_W-1:0]          next_index_o,
  output logic signed [ecs_pkg::COUNT_W-1:0]       next_count_o,
  output logic                                     any_pending_o,
  output logic                                     query_active_o
);

  // front to back queue
  ecs_pkg::cmd_t cmd;
  logic          cmd_empty;
  logic          cmd_pop;

  // back end result and the output word register
  ecs_pkg::res_t res;
  logic          res_valid;
  logic          out_ready;
  logic          out_valid_q, out_valid_d;
  ecs_pkg::res_t out_q;

  ecs_front u_front (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push_i),
    .full_o           (full_o),
    .action_i         (action_i),
    .handler_index_i  (handler_index_i),
    .cycle_time_i     (cycle_time_i),
    .elapsed_cycles_i (elapsed_cycles_i),
    .cmd_pop_i        (cmd_pop),
    .cmd_empty_o      (cmd_empty),
    .cmd_o            (cmd)
  );

  ecs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .out_ready_i (out_ready),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // room for a new word when empty or when the waiting word leaves now
  assign out_ready = !out_valid_q || pop_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid) begin
      out_valid_d = 1'b1;
    end else if (pop_i && out_valid_q) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign empty_o        = !out_valid_q;
  assign next_index_o   = out_q.next_index;
  assign next_count_o   = out_q.next_count;
  assign any_pending_o  = out_q.any_pending;
  assign query_active_o = out_q.query_active;

endmodule

`default_nettype wire

// ===== hw/rtl/ecs_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ecs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ecs_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ecs_front (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             push_i,
  output logic                                  full_o,
  input  wire logic [ecs_pkg::ACTION_W-1:0]     action_i,
  input  wire logic [ecs_pkg::HIDX_W-1:0]       handler_index_i,
  input  wire logic [ecs_pkg::CT_W-1:0]         cycle_time_i,
  input  wire logic [ecs_pkg::EL_W-1:0]         elapsed_cycles_i,
  input  wire logic                             cmd_pop_i,
  output logic                                  cmd_empty_o,
  output ecs_pkg::cmd_t                         cmd_o
);

  localparam int CMP_W =
    (ecs_pkg::TIME_BITS > ecs_pkg::CT_W ? ecs_pkg::TIME_BITS : ecs_pkg::CT_W) + 1;

  ecs_pkg::cmd_t                     cmd_in;
  logic [CMP_W-1:0]                  ct_x;
  logic [CMP_W-1:0]                  tmax_x;
  ecs_pkg::cmd_t                     q_mem_q [ecs_pkg::CMDQ_DEPTH];
  logic [ecs_pkg::CMDQ_PTR_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [ecs_pkg::CMDQ_CNT_W-1:0]    cnt_q, cnt_d;
  logic                              do_push, do_pop;

  // decode and clamp the incoming word
  always_comb begin
    ct_x   = CMP_W'(cycle_time_i);
    tmax_x = CMP_W'(ecs_pkg::TIME_MAX);
    cmd_in.slot_ok = (handler_index_i != '0) &&
                     (32'(handler_index_i) < ecs_pkg::NUM_EVENTS);
    cmd_in.slot    = ecs_pkg::SLOT_W'(handler_index_i);
    cmd_in.ct      = (ct_x > tmax_x) ? ecs_pkg::TIME_MAX : ecs_pkg::time_t'(ct_x);
    cmd_in.el      = elapsed_cycles_i;
    case (action_i)
      ecs_pkg::ACT_ADVANCE: cmd_in.op = ecs_pkg::OP_ADVANCE;
      ecs_pkg::ACT_ADD:     cmd_in.op = ecs_pkg::OP_ADD;
      ecs_pkg::ACT_REMOVE:  cmd_in.op = ecs_pkg::OP_REMOVE;
      ecs_pkg::ACT_ACK:     cmd_in.op = ecs_pkg::OP_ACK;
      ecs_pkg::ACT_QUERY:   cmd_in.op = ecs_pkg::OP_QUERY;
      default:              cmd_in.op = ecs_pkg::OP_NOP;
    endcase
  end

  assign full_o      = (cnt_q == ecs_pkg::CMDQ_CNT_W'(ecs_pkg::CMDQ_DEPTH));
  assign cmd_empty_o = (cnt_q == '0);
  assign do_push     = push_i && !full_o;
  assign do_pop      = cmd_pop_i && !cmd_empty_o;
  assign cmd_o       = q_mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (32'(wr_ptr_q) == ecs_pkg::CMDQ_DEPTH - 1) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (32'(rd_ptr_q) == ecs_pkg::CMDQ_DEPTH - 1) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!do_push && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      q_mem_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/ecs_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ecs_back (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_empty_i,
  input  wire ecs_pkg::cmd_t cmd_i,
  output logic               cmd_pop_o,
  input  wire logic          out_ready_i,
  output logic               res_valid_o,
  output ecs_pkg::res_t      res_o
);

  localparam int CNT_W = ecs_pkg::SLOT_W + 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(ecs_pkg::NUM_EVENTS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_e;

  state_e                           state_q, state_d;
  ecs_pkg::cmd_t                    cmd_q, cmd_d;
  ecs_pkg::time_t                   elapsed_q, elapsed_d;
  logic                             rebase_q, rebase_d;
  logic [CNT_W-1:0]                 cnt_q, cnt_d;
  logic [ecs_pkg::NUM_EVENTS-1:0]   active_q, active_d;
  logic [ecs_pkg::SLOT_W-1:0]       soonest_q, soonest_d;
  ecs_pkg::time_t                   countdown_q, countdown_d;
  ecs_pkg::time_t                   soon_time_q, soon_time_d;
  ecs_pkg::time_t                   best_q, best_d;
  logic [ecs_pkg::SLOT_W-1:0]       best_idx_q, best_idx_d;

  logic                             ram_re, ram_we;
  logic [ecs_pkg::SLOT_W-1:0]       ram_raddr, proc_idx;
  ecs_pkg::time_t                   ram_rdata, t_new;
  logic                             act_new, hit;

  ecs_ram #(
    .WIDTH(ecs_pkg::TIME_BITS),
    .DEPTH(ecs_pkg::NUM_EVENTS)
  ) u_time_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (proc_idx),
    .wdata_i (t_new),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    elapsed_d   = elapsed_q;
    rebase_d    = rebase_q;
    cnt_d       = cnt_q;
    active_d    = active_q;
    soonest_d   = soonest_q;
    countdown_d = countdown_q;
    soon_time_d = soon_time_q;
    best_d      = best_q;
    best_idx_d  = best_idx_q;
    cmd_pop_o   = 1'b0;
    res_valid_o = 1'b0;
    ram_re      = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = cnt_q[ecs_pkg::SLOT_W-1:0];
    proc_idx    = ecs_pkg::SLOT_W'(cnt_q - 1'b1);
    act_new     = active_q[proc_idx];
    hit         = 1'b0;
    t_new       = ram_rdata;
    res_o.next_index   = ecs_pkg::HIDX_W'(soonest_q);
    res_o.next_count   = ecs_pkg::COUNT_W'(countdown_q);
    res_o.any_pending  = |active_q;
    res_o.query_active = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.op)
            ecs_pkg::OP_ADD, ecs_pkg::OP_REMOVE, ecs_pkg::OP_ACK: begin
              cmd_pop_o  = 1'b1;
              cmd_d      = cmd_i;
              elapsed_d  = ecs_pkg::sat_sub(soon_time_q, countdown_q);
              // an add with no soonest slot leaves the table times alone
              rebase_d   = !((cmd_i.op == ecs_pkg::OP_ADD) && (soonest_q == '0));
              best_d     = ecs_pkg::TIME_MAX;
              best_idx_d = '0;
              cnt_d      = '0;
              state_d    = ST_SCAN;
            end
            ecs_pkg::OP_ADVANCE: begin
              if (out_ready_i) begin
                cmd_pop_o   = 1'b1;
                res_valid_o = 1'b1;
                countdown_d = ecs_pkg::sat_sub(countdown_q,
                                               ecs_pkg::time_t'(cmd_i.el));
                res_o.next_count = ecs_pkg::COUNT_W'(countdown_d);
              end
            end
            ecs_pkg::OP_QUERY: begin
              if (out_ready_i) begin
                cmd_pop_o          = 1'b1;
                res_valid_o        = 1'b1;
                res_o.query_active = cmd_i.slot_ok && active_q[cmd_i.slot];
              end
            end
            default: begin
              if (out_ready_i) begin
                cmd_pop_o   = 1'b1;
                res_valid_o = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SCAN: begin
        ram_re = (cnt_q != CNT_LAST);
        if (cnt_q != '0) begin
          // rebase, apply the command to this slot, then fold into the minimum
          ram_we = 1'b1;
          if (act_new && rebase_q) begin
            t_new = ecs_pkg::sat_sub(ram_rdata, elapsed_q);
          end
          hit = cmd_q.slot_ok && (proc_idx == cmd_q.slot);
          if ((cmd_q.op == ecs_pkg::OP_ADD) && hit) begin
            act_new = 1'b1;
            t_new   = cmd_q.ct;
          end else if ((cmd_q.op == ecs_pkg::OP_REMOVE) && hit) begin
            act_new = 1'b0;
          end else if ((cmd_q.op == ecs_pkg::OP_ACK) && (soonest_q != '0) &&
                       (proc_idx == soonest_q)) begin
            act_new = 1'b0;
          end
          active_d[proc_idx] = act_new;
          if (act_new && (proc_idx != '0) && (t_new < best_q)) begin
            best_d     = t_new;
            best_idx_d = proc_idx;
          end
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_LAST) begin
          soonest_d   = best_idx_d;
          countdown_d = (best_idx_d != '0) ? best_d : ecs_pkg::TIME_MAX;
          soon_time_d = countdown_d;
          state_d     = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_ready_i) begin
          res_valid_o = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      active_q    <= '0;
      soonest_q   <= '0;
      countdown_q <= '0;
      soon_time_q <= ecs_pkg::TIME_MAX;
      cnt_q       <= '0;
      rebase_q    <= 1'b0;
      cmd_q       <= '0;
      elapsed_q   <= '0;
      best_q      <= ecs_pkg::TIME_MAX;
      best_idx_q  <= '0;
    end else begin
      state_q     <= state_d;
      active_q    <= active_d;
      soonest_q   <= soonest_d;
      countdown_q <= countdown_d;
      soon_time_q <= soon_time_d;
      cnt_q       <= cnt_d;
      rebase_q    <= rebase_d;
      cmd_q       <= cmd_d;
      elapsed_q   <= elapsed_d;
      best_q      <= best_d;
      best_idx_q  <= best_idx_d;
    end
  end

`include "event_countdown_scheduler_assert.svh"

  `ECS_ASSERT(a_null_slot_idle, !active_q[0])
  `ECS_ASSERT(a_soonest_active,
              !((state_q == ST_IDLE) && (soonest_q != '0)) || active_q[soonest_q])
  `ECS_ASSERT(a_idle_time_max, (soonest_q != '0) || (soon_time_q == ecs_pkg::TIME_MAX))
  `ECS_ASSERT(a_res_has_room, !res_valid_o || out_ready_i)
  `ECS_ASSERT_NEXT(a_scan_ends, (state_q == ST_SCAN) && (cnt_q == CNT_LAST),
                   state_q == ST_DONE)

endmodule

`default_nettype wire

// ===== test/tb_event_countdown_scheduler.sv =====
`timescale 1ns / 1ps

module tb_event_countdown_scheduler;

  import ecs_pkg::*;

  // actions beyond query carry no meaning and only report the state
  localparam logic [ACTION_W-1:0] ACT_UNUSED_LO = 3'd5;
  localparam logic [ACTION_W-1:0] ACT_UNUSED_HI = 3'd7;

  localparam logic [CT_W-1:0] CT_ALL_ONES = {CT_W{1'b1}};
  localparam logic [EL_W-1:0] EL_ALL_ONES = {EL_W{1'b1}};

  // words per idling mode before moving on to the next one
  localparam int unsigned MODE_SPAN    = 40;
  localparam int unsigned RANDOM_WORDS = 400;
  // this covers any word still in flight after the last answer
  localparam int unsigned DRAIN_CYCLES = 4 * NUM_EVENTS;

  typedef enum int unsigned {
    MODE_STEADY,
    MODE_SENDER_GAPS,
    MODE_RECEIVER_STALLS,
    MODE_BOTH
  } idle_mode_e;

  // one command word as it sits on the input ports
  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [HIDX_W-1:0]   hidx;
    logic [CT_W-1:0]     ct;
    logic [EL_W-1:0]     el;
  } cmd_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // every input is known from time zero
  logic                push_i           = 1'b0;
  logic                pop_i            = 1'b0;
  logic [ACTION_W-1:0] action_i         = ACT_QUERY;
  logic [HIDX_W-1:0]   handler_index_i  = '0;
  logic [CT_W-1:0]     cycle_time_i     = '0;
  logic [EL_W-1:0]     elapsed_cycles_i = '0;

  logic                      full_o;
  logic                      empty_o;
  logic [HIDX_W-1:0]         next_index_o;
  logic signed [COUNT_W-1:0] next_count_o;
  logic                      any_pending_o;
  logic                      query_active_o;

  event_countdown_scheduler DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .push_i           (push_i),
    .full_o           (full_o),
    .action_i         (action_i),
    .handler_index_i  (handler_index_i),
    .cycle_time_i     (cycle_time_i),
    .elapsed_cycles_i (elapsed_cycles_i),
    .empty_o          (empty_o),
    .pop_i            (pop_i),
    .next_index_o     (next_index_o),
    .next_count_o     (next_count_o),
    .any_pending_o    (any_pending_o),
    .query_active_o   (query_active_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // commands still to be sent and the answers still owed by the block
  cmd_word_t cmd_backlog [$];
  res_t      schedule_expected [$];

  int unsigned words_accepted = 0;
  int unsigned total_words    = 0;
  int unsigned mismatches     = 0;

  // shadow copy of the event table
  logic [NUM_EVENTS-1:0] sched_active    = '0;
  time_t                 sched_time [NUM_EVENTS];
  logic [HIDX_W-1:0]     sched_soonest   = '0;
  time_t                 sched_countdown = '0;

  // a - b pinned to the signed time range
  function automatic time_t time_sub_clamped(input time_t a, input time_t b);
    logic signed [TIME_BITS:0] wide;
    time_t                     r;
    wide = a - b;
    if (wide > TIME_MAX) begin
      r = TIME_MAX;
    end else if (wide < TIME_MIN) begin
      r = TIME_MIN;
    end else begin
      r = wide[TIME_BITS-1:0];
    end
    return r;
  endfunction

  // move every live slot forward by what has run since the last scan
  function automatic void shift_slot_times();
    time_t elapsed;
    elapsed = time_sub_clamped(sched_time[sched_soonest], sched_countdown);
    for (int i = 0; i < NUM_EVENTS; i++) begin
      if (sched_active[i]) begin
        sched_time[i] = time_sub_clamped(sched_time[i], elapsed);
      end
    end
  endfunction

  // earliest live slot wins, lowest index on a tie; slot 0 never takes part
  function automatic void find_soonest();
    time_t             best;
    logic [HIDX_W-1:0] idx;
    best = TIME_MAX;
    idx  = '0;
    for (int i = 1; i < NUM_EVENTS; i++) begin
      if (sched_active[i] && sched_time[i] < best) begin
        best = sched_time[i];
        idx  = i[HIDX_W-1:0];
      end
    end
    sched_soonest   = idx;
    sched_countdown = (idx != 0) ? sched_time[idx] : TIME_MAX;
  endfunction

  // apply one command to the shadow table and return the answer word
  function automatic res_t predict_schedule(input cmd_word_t w);
    res_t  r;
    bit    slot_ok;
    time_t step;
    time_t due;
    slot_ok = (w.hidx != 0) && (int'(w.hidx) < NUM_EVENTS);
    step    = {{(TIME_BITS-EL_W){1'b0}}, w.el};
    // a 40-bit cycle time always fits below the time maximum
    due     = {{(TIME_BITS-CT_W){1'b0}}, w.ct};
    r       = '0;
    case (w.action)
      ACT_ADVANCE: begin
        sched_countdown = time_sub_clamped(sched_countdown, step);
      end
      ACT_ADD: begin
        // nothing to rebase against when the table is idle
        if (sched_soonest != 0) begin
          shift_slot_times();
        end
        if (slot_ok) begin
          sched_active[w.hidx] = 1'b1;
          sched_time[w.hidx]   = due;
        end
        find_soonest();
      end
      ACT_REMOVE: begin
        shift_slot_times();
        if (slot_ok) begin
          sched_active[w.hidx] = 1'b0;
        end
        find_soonest();
      end
      ACT_ACK: begin
        shift_slot_times();
        if (sched_soonest != 0) begin
          sched_active[sched_soonest] = 1'b0;
        end
        find_soonest();
      end
      ACT_QUERY: begin
        r.query_active = slot_ok && sched_active[w.hidx];
      end
      default: begin
      end
    endcase
    r.next_index  = sched_soonest;
    r.next_count  = sched_countdown;
    r.any_pending = |sched_active;
    return r;
  endfunction

  // idling follows the word count: steady, sender gaps, receiver stalls, both
  function automatic bit hold_off(input bit receiver);
    idle_mode_e  mode;
    int unsigned roll;
    bit          idle;
    mode = idle_mode_e'((words_accepted / MODE_SPAN) % 4);
    roll = $urandom_range(99);
    case (mode)
      MODE_SENDER_GAPS:     idle = !receiver && roll < 52;
      MODE_RECEIVER_STALLS: idle = receiver && roll < 52;
      MODE_BOTH:            idle = roll < 11;
      default:              idle = 1'b0;
    endcase
    return idle;
  endfunction

  task automatic queue_word(input logic [ACTION_W-1:0] action, input logic [HIDX_W-1:0] hidx,
                            input logic [CT_W-1:0] ct, input logic [EL_W-1:0] el);
    cmd_word_t w;
    w.action = action;
    w.hidx   = hidx;
    w.ct     = ct;
    w.el     = el;
    cmd_backlog.push_back(w);
  endtask

  // mostly short due times so that advances make events late
  function automatic logic [CT_W-1:0] rand_cycle_time();
    logic [63:0]     raw;
    logic [CT_W-1:0] ct;
    int unsigned     pick;
    raw  = {$urandom(), $urandom()};
    pick = $urandom_range(99);
    if (pick < 50) begin
      ct = CT_W'($urandom_range(200000));
    end else if (pick < 75) begin
      ct = CT_W'(raw[19:0]);
    end else if (pick < 90) begin
      ct = raw[CT_W-1:0];
    end else begin
      ct = raw[0] ? CT_ALL_ONES : '0;
    end
    return ct;
  endfunction

  function automatic logic [EL_W-1:0] rand_elapsed();
    int unsigned     pick;
    logic [EL_W-1:0] el;
    pick = $urandom_range(99);
    if (pick < 50) begin
      el = EL_W'($urandom());
    end else if (pick < 80) begin
      el = EL_W'($urandom_range(255));
    end else begin
      el = pick[0] ? EL_ALL_ONES : '0;
    end
    return el;
  endfunction

  // driver: presents the backlog one word at a time, holds while full
  cmd_word_t on_wire;
  cmd_word_t next_word;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_i <= 1'b0;
    end else begin
      if (push_i && !full_o) begin
        // word taken at this edge: predict its answer now, in order
        on_wire = {action_i, handler_index_i, cycle_time_i, elapsed_cycles_i};
        schedule_expected.push_back(predict_schedule(on_wire));
        words_accepted <= words_accepted + 1;
      end
      if (!push_i || !full_o) begin
        if (cmd_backlog.size() != 0 && !hold_off(1'b0)) begin
          next_word = cmd_backlog.pop_front();
          action_i         <= next_word.action;
          handler_index_i  <= next_word.hidx;
          cycle_time_i     <= next_word.ct;
          elapsed_cycles_i <= next_word.el;
          push_i           <= 1'b1;
        end else begin
          push_i <= 1'b0;
        end
      end
    end
  end

  // monitor: pops answer words and checks them against the oldest prediction
  res_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop_i <= 1'b0;
    end else begin
      if (pop_i && !empty_o) begin
        if (schedule_expected.size() == 0) begin
          $error("answer word with no command waiting for it");
          mismatches++;
        end else begin
          want = schedule_expected.pop_front();
          if (next_index_o !== want.next_index) begin
            $error("next_index: expected %0d, got %0d", want.next_index, next_index_o);
            mismatches++;
          end
          if (next_count_o !== want.next_count) begin
            $error("next_count: expected %0d, got %0d", want.next_count, next_count_o);
            mismatches++;
          end
          if (any_pending_o !== want.any_pending) begin
            $error("any_pending: expected %0b, got %0b", want.any_pending, any_pending_o);
            mismatches++;
          end
          if (query_active_o !== want.query_active) begin
            $error("query_active: expected %0b, got %0b", want.query_active, query_active_o);
            mismatches++;
          end
        end
      end
      pop_i <= !hold_off(1'b1);
    end
  end

  initial begin
    int unsigned       pick;
    logic [HIDX_W-1:0] hidx;
    logic [ACTION_W-1:0] act;

    for (int i = 0; i < NUM_EVENTS; i++) begin
      sched_time[i] = TIME_MAX;
    end

    // directed: idle table, null slot, late countdown, ties, extremes
    queue_word(ACT_QUERY, 4'd0, CT_ALL_ONES, EL_ALL_ONES);
    queue_word(ACT_REMOVE, 4'd5, '0, '0);
    queue_word(ACT_ACK, 4'd0, '0, '0);
    // countdown runs negative before anything is scheduled
    queue_word(ACT_ADVANCE, 4'd0, '0, EL_ALL_ONES);
    queue_word(ACT_ADVANCE, 4'd0, '0, '0);
    // add to the null slot only rescans
    queue_word(ACT_ADD, 4'd0, 40'd100, '0);
    queue_word(ACT_ADD, 4'd15, CT_ALL_ONES, '0);
    queue_word(ACT_ADD, 4'd1, '0, '0);
    // same due time: lower index stays soonest
    queue_word(ACT_ADD, 4'd3, '0, '0);
    queue_word(ACT_QUERY, 4'd1, '0, '0);
    queue_word(ACT_QUERY, 4'd15, '0, '0);
    queue_word(ACT_QUERY, 4'd2, '0, '0);
    // soonest event goes late, then an add rebases the table
    queue_word(ACT_ADVANCE, 4'd0, '0, EL_ALL_ONES);
    queue_word(ACT_ADVANCE, 4'd0, '0, 16'h1234);
    queue_word(ACT_ADD, 4'd7, 40'd50, '0);
    queue_word(ACT_ACK, 4'd0, '0, '0);
    queue_word(ACT_ACK, 4'd0, '0, '0);
    queue_word(ACT_REMOVE, 4'd0, '0, '0);
    queue_word(ACT_REMOVE, 4'd15, '0, '0);
    for (int a = ACT_UNUSED_LO; a <= ACT_UNUSED_HI; a++) begin
      queue_word(a[ACTION_W-1:0], 4'd9, 40'h5555555555, 16'hAAAA);
    end
    queue_word(ACT_ADD, 4'd15, 40'h5555555555, '0);
    queue_word(ACT_ADD, 4'd10, 40'hAAAAAAAAAA, '0);
    queue_word(ACT_ACK, 4'd0, '0, '0);
    queue_word(ACT_ACK, 4'd0, '0, '0);

    // random: mostly schedule, run and retire events, some queries and noise
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      pick = $urandom_range(99);
      hidx = ($urandom_range(9) == 0) ? 4'd0 : 4'($urandom_range(NUM_EVENTS - 1, 1));
      if (pick < 30) begin
        act = ACT_ADVANCE;
      end else if (pick < 55) begin
        act = ACT_ADD;
      end else if (pick < 67) begin
        act = ACT_REMOVE;
      end else if (pick < 82) begin
        act = ACT_ACK;
      end else if (pick < 95) begin
        act = ACT_QUERY;
      end else begin
        act = ACTION_W'($urandom_range(ACT_UNUSED_HI, ACT_UNUSED_LO));
      end
      queue_word(act, hidx, rand_cycle_time(), rand_elapsed());
    end
    total_words = cmd_backlog.size();

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (words_accepted != total_words) @(posedge clk_i);
    while (schedule_expected.size() != 0) @(posedge clk_i);
    // let any stray answer word show up before judging
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("** event_countdown_scheduler: PASSED **");
    end else begin
      $display("** event_countdown_scheduler: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(10_000_000);
    $display("** event_countdown_scheduler: FAILED **");
    $finish;
  end

endmodule

// ===== event_countdown_scheduler.f =====
+incdir+hw/rtl
hw/rtl/ecs_pkg.sv
hw/rtl/ecs_ram.sv
hw/rtl/ecs_front.sv
hw/rtl/ecs_back.sv
hw/rtl/event_countdown_scheduler.sv
test/tb_event_countdown_scheduler.sv
